// ----- hdl/rvaa_pkg.sv -----
// Shared types, codes and constants of the axis rotation pipeline.
// No dependencies; every other file of the block except rvaa_if imports this package.
package rvaa_pkg;

	// Default fraction width of the internal sine and cosine values.
	localparam int TRIG_FRAC_BITS_DEF = 16;

	// Axis codes carried on the input channel.
	localparam logic [1:0] AXIS_NONE = 2'd0;
	localparam logic [1:0] AXIS_X    = 2'd1;
	localparam logic [1:0] AXIS_Y    = 2'd2;
	localparam logic [1:0] AXIS_Z    = 2'd3;

	// Quadrant of the reduced angle.
	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	// 1.0 in unsigned Q0.32 (needs the 33rd bit).
	localparam logic [32:0] TRIG_ONE = 33'h1_0000_0000;

	// Series cells: each cell does one sine term and one cosine term.
	// A divisor of zero marks a lane that only passes its term on.
	localparam int NUM_CELLS = 6;
	localparam int SDIV_TAB [NUM_CELLS] = '{0, 110, 72, 42, 20, 6};
	localparam int CDIV_TAB [NUM_CELLS] = '{132, 90, 56, 30, 12, 2};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [23:0] angle;
		logic [1:0]         axis;
	} vec_t;

	// Per-item context that rides along the whole pipeline.
	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [1:0]         axis;
		logic [1:0]         quad;
		logic               swap;
	} ctx_t;

	// What one series cell hands to the next.
	typedef struct packed {
		ctx_t        ctx;
		logic [31:0] x;
		logic [31:0] x2;
		logic [32:0] ts;
		logic [32:0] tc;
	} term_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} res_t;

endpackage

// ----- hdl/rvaa_if.sv -----
// Channel interfaces of the axis rotation block: input vectors and results.
// Valid/ready handshake; no package dependency.
interface rvaa_vec_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [23:0] angle;
	logic [1:0]         axis_code;

	modport source (output valid, output vec_x, output vec_y, output vec_z,
		output angle, output axis_code, input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z,
		input angle, input axis_code, output ready);
endinterface

interface rvaa_rot_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] rot_x;
	logic signed [31:0] rot_y;
	logic signed [31:0] rot_z;

	modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
	modport sink (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

// ----- hdl/rotate_vector_about_axis.sv -----
// Top level of the axis rotation block: front end, series cells, back end, output skid.
// Depends on rvaa_pkg, rvaa_if, rvaa_angle, rvaa_cell and rvaa_rotate.
//
//  channel | modport | payload                                  | transaction when
//  --------+---------+------------------------------------------+-------------------
//  vec     | sink    | vec_x vec_y vec_z (Q16.16) angle axis_code | valid && ready
//  rot     | source  | rot_x rot_y rot_z (Q16.16, saturated)     | valid && ready
//
// One transaction per cycle while rot keeps taking results; a result passes 9 front-end stages,
// 6 cells of 4 stages and 7 back-end stages on its way to the output register.
// arst_n clears every valid bit at once; no clearing pass, the block takes input right away.
// The whole pipeline advances together while the skid register is empty, so vec.ready is a
// flop output. A stalled result parks in the output register and the next one in the skid,
// then the pipeline holds until rot drains the skid.
module rotate_vector_about_axis import rvaa_pkg::*; #(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rvaa_vec_if.sink    vec,
	rvaa_rot_if.source  rot
);

	logic  en;
	vec_t  vin;
	logic  chain_vld [NUM_CELLS+1];
	term_t chain_trm [NUM_CELLS+1];
	logic  pipe_vld;
	res_t  pipe_res;
	logic  pipe_exit;
	logic  out_free;

	logic  out_vld_q, skid_vld_q;
	res_t  out_q, skid_q;

	// Advance everything while the skid is free to catch one more result.
	assign en        = !skid_vld_q;
	assign vec.ready = en;

	assign vin.x     = vec.vec_x;
	assign vin.y     = vec.vec_y;
	assign vin.z     = vec.vec_z;
	assign vin.angle = vec.angle;
	assign vin.axis  = vec.axis_code;

	// Angle reduction, octant fold and x, x^2 in Q0.32.
	rvaa_angle u_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vec.valid),
		.vin    (vin),
		.vld_o  (chain_vld[0]),
		.term_o (chain_trm[0])
	);

	// Row of series cells; cell i evaluates the i-th Horner step of sine and cosine.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		rvaa_cell #(
			.SDIV (SDIV_TAB[i]),
			.CDIV (CDIV_TAB[i])
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (chain_vld[i]),
			.term_i (chain_trm[i]),
			.vld_o  (chain_vld[i+1]),
			.term_o (chain_trm[i+1])
		);
	end

	// Final sine product, quadrant unfold and the rotation itself.
	rvaa_rotate #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_rotate (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (chain_vld[NUM_CELLS]),
		.term_i (chain_trm[NUM_CELLS]),
		.vld_o  (pipe_vld),
		.res_o  (pipe_res)
	);

	assign pipe_exit = en && pipe_vld;
	assign out_free  = !out_vld_q || rot.ready;

	// Output register and skid: drain the skid first, else take the pipeline's result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q  <= skid_vld_q || pipe_exit;
			skid_vld_q <= 1'b0;
		end else if (pipe_exit) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : pipe_res;
		end else if (pipe_exit) begin
			skid_q <= pipe_res;
		end
	end

	assign rot.valid = out_vld_q;
	assign rot.rot_x = out_q.x;
	assign rot.rot_y = out_q.y;
	assign rot.rot_z = out_q.z;

	// The skid only ever holds the result behind a waiting one.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a result while the output register is empty");

	// A result leaving the pipeline into a stalled output must land in the skid.
	a_exit_caught: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_exit && out_vld_q && !rot.ready) |=> skid_vld_q)
		else $error("result left the pipeline while the output was stalled and was dropped");

	// Draining the skid refills the output and frees the pipeline for the next cycle.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && rot.ready) |=> (out_vld_q && !skid_vld_q))
		else $error("skid did not move into the output register when taken");

endmodule

// ----- hdl/rvaa_angle.sv -----
// Angle front end: reduce modulo 360 degrees, fold to one octant, form x and x^2.
// Nine pipeline stages. Depends on rvaa_pkg.
module rvaa_angle import rvaa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_i,
	input  vec_t  vin,
	output logic  vld_o,
	output term_t term_o
);

	localparam int ANG_LO_BITS   = 11;
	localparam int TURN_UNITS    = 92160;
	localparam int QUARTER_UNITS = TURN_UNITS / 4;
	localparam int EIGHTH_UNITS  = TURN_UNITS / 8;
	localparam int TURN_HI       = TURN_UNITS >> ANG_LO_BITS;
	localparam int HI_BIAS       = TURN_HI * 92;
	localparam int RCP_S16       = (1 << 16) / TURN_HI;
	localparam int RCP_S24       = (1 << 24) / TURN_HI;
	localparam longint unsigned PI_Q32 = 64'd13493037705;
	localparam longint unsigned PI_QUO = PI_Q32 / (TURN_UNITS / 2);
	localparam longint unsigned PI_REM = PI_Q32 % (TURN_UNITS / 2);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9;

	logic [13:0] vv_s1;
	logic [7:0]  q0_s1;
	logic [10:0] lo_s1, lo_s2;
	logic [5:0]  m_s2;
	logic [14:0] f_s3;
	logic [13:0] g_s4;
	logic [31:0] hi_s5, hi_s6;
	logic [28:0] ml_s5;
	logic [18:0] md_s6;
	logic [12:0] qd0_s6;
	logic [31:0] x_s7, x_s8, x_s9;
	logic [63:0] xx_s8;
	logic [31:0] x2_s9;

	logic signed [12:0] ang_hi;
	logic signed [14:0] vv_sum;
	logic [24:0]        q0_prod;
	logic [13:0]        m_raw;
	logic [7:0]         tq;
	logic [7:0]         fh;
	logic [1:0]         quad;
	logic               swap;
	logic [18:0]        rr;
	logic [37:0]        qd_prod;
	logic [12:0]        qd;
	ctx_t               ctx_in;

	// Stage 1: bias the upper angle bits so the modulo works on a non-negative value.
	always_comb begin
		ang_hi  = vin.angle[23:ANG_LO_BITS];
		vv_sum  = 15'(ang_hi) + 15'(HI_BIAS);
		q0_prod = 25'(vv_sum[13:0]) * 25'(RCP_S16);
		ctx_in.vx   = vin.x;
		ctx_in.vy   = vin.y;
		ctx_in.vz   = vin.z;
		ctx_in.axis = vin.axis;
		ctx_in.quad = QUAD_I;
		ctx_in.swap = 1'b0;
	end

	// Stage 2: remainder of the upper bits by 45, one correction step.
	assign m_raw = vv_s1 - 14'(q0_s1) * 14'(TURN_HI);

	// Stage 3: quadrant and offset within it.
	always_comb begin
		tq = {m_s2, lo_s2[10:9]};
		if (tq >= 8'(3 * TURN_HI)) begin
			quad = QUAD_IV;
			fh   = tq - 8'(3 * TURN_HI);
		end else if (tq >= 8'(2 * TURN_HI)) begin
			quad = QUAD_III;
			fh   = tq - 8'(2 * TURN_HI);
		end else if (tq >= 8'(TURN_HI)) begin
			quad = QUAD_II;
			fh   = tq - 8'(TURN_HI);
		end else begin
			quad = QUAD_I;
			fh   = tq;
		end
	end

	// Stage 4: fold the upper octant onto the lower one.
	assign swap = f_s3 > 15'(EIGHTH_UNITS);

	// Stage 6: reciprocal estimate of the quotient by 45, low by at most one.
	assign qd_prod = 38'(ml_s5[28:10]) * 38'(RCP_S24);

	// Stage 7: correct the quotient and form x in Q0.32.
	assign rr      = md_s6 - 19'(qd0_s6) * 19'(TURN_HI);
	assign qd      = (rr >= 19'(TURN_HI)) ? qd0_s6 + 13'd1 : qd0_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			vv_s1  <= vv_sum[13:0];
			q0_s1  <= 8'(q0_prod >> 16);
			lo_s1  <= vin.angle[ANG_LO_BITS-1:0];

			ctx_s2 <= ctx_s1;
			m_s2   <= (m_raw >= 14'(TURN_HI)) ? 6'(m_raw - 14'(TURN_HI)) : 6'(m_raw);
			lo_s2  <= lo_s1;

			ctx_s3 <= {ctx_s2.vx, ctx_s2.vy, ctx_s2.vz, ctx_s2.axis, quad, ctx_s2.swap};
			f_s3   <= {fh[5:0], lo_s2[8:0]};

			ctx_s4 <= {ctx_s3.vx, ctx_s3.vy, ctx_s3.vz, ctx_s3.axis, ctx_s3.quad, swap};
			g_s4   <= swap ? 14'(15'(QUARTER_UNITS) - f_s3) : f_s3[13:0];

			ctx_s5 <= ctx_s4;
			hi_s5  <= 32'(g_s4) * 32'(PI_QUO);
			ml_s5  <= 29'(g_s4) * 29'(PI_REM) + 29'(QUARTER_UNITS);

			ctx_s6 <= ctx_s5;
			hi_s6  <= hi_s5;
			md_s6  <= ml_s5[28:10];
			qd0_s6 <= 13'(qd_prod >> 24);

			ctx_s7 <= ctx_s6;
			x_s7   <= hi_s6 + 32'(qd);

			ctx_s8 <= ctx_s7;
			x_s8   <= x_s7;
			xx_s8  <= 64'(x_s7) * 64'(x_s7);

			ctx_s9 <= ctx_s8;
			x_s9   <= x_s8;
			x2_s9  <= xx_s8[63:32] + 32'(xx_s8[31]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9} <= '0;
		end else if (en) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9} <=
				{vld_i, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8};
		end
	end

	assign vld_o       = vld_s9;
	assign term_o.ctx  = ctx_s9;
	assign term_o.x    = x_s9;
	assign term_o.x2   = x2_s9;
	assign term_o.ts   = TRIG_ONE;
	assign term_o.tc   = TRIG_ONE;

endmodule

// ----- hdl/rvaa_cell.sv -----
// Series cell: one Horner step t = 1 - round(x2*t)/d for the sine and cosine lanes.
// Four pipeline stages. Depends on rvaa_pkg.
module rvaa_cell import rvaa_pkg::*; #(
	parameter int SDIV = 110,
	parameter int CDIV = 132
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_i,
	input  term_t term_i,
	output logic  vld_o,
	output term_t term_o
);

	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	term_t trm_s1, trm_s2, trm_s3, trm_s4;
	logic [32:0] t_nxt [2];

	for (genvar l = 0; l < 2; l++) begin : g_lane
		localparam int D = (l == 0) ? SDIV : CDIV;
		if (D == 0) begin : g_pass
			// Hold the incoming term unchanged.
			assign t_nxt[l] = (l == 0) ? trm_s3.ts : trm_s3.tc;
		end else begin : g_div
			// Exact floor division by D through a rounded-up reciprocal.
			localparam int L = $clog2(D);
			localparam logic [64:0] M = 65'(((65'd1 << (32 + L)) + 65'(D) - 65'd1) / 65'(D));
			logic [32:0] tin;
			logic [63:0] p_s1;
			logic [31:0] v_s2;
			logic [64:0] m_s3;

			assign tin = (l == 0) ? term_i.ts : term_i.tc;

			always_ff @(posedge clk) begin
				if (en) begin
					p_s1 <= 64'(term_i.x2) * 64'(tin);
					v_s2 <= p_s1[63:32] + 32'(p_s1[31]);
					m_s3 <= 65'(v_s2) * M;
				end
			end

			assign t_nxt[l] = TRIG_ONE - 33'(m_s3 >> (32 + L));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trm_s1 <= term_i;
			trm_s2 <= trm_s1;
			trm_s3 <= trm_s2;
			trm_s4 <= {trm_s3.ctx, trm_s3.x, trm_s3.x2, t_nxt[0], t_nxt[1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4} <= '0;
		end else if (en) begin
			{vld_s1, vld_s2, vld_s3, vld_s4} <= {vld_i, vld_s1, vld_s2, vld_s3};
		end
	end

	assign vld_o  = vld_s4;
	assign term_o = trm_s4;

endmodule

// ----- hdl/rvaa_rotate.sv -----
// Back end: finish sine, unfold octant and quadrant, rotate, round and saturate.
// Seven pipeline stages. Depends on rvaa_pkg.
module rvaa_rotate import rvaa_pkg::*; #(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_i,
	input  term_t term_i,
	output logic  vld_o,
	output res_t  res_o
);

	localparam int F  = TRIG_FRAC_BITS;
	localparam int PW = F + 34;
	localparam int SW = PW + 1;
	localparam int RW = SW - F;
	localparam logic [32:0] TRIG_RND = 33'd1 << (31 - F);
	localparam logic signed [SW-1:0] SUM_RND = SW'(1) << (F - 1);
	localparam logic signed [RW-1:0] SAT_HI = RW'(32'sh7fffffff);
	localparam logic signed [RW-1:0] SAT_LO = RW'(32'sh80000000);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;

	logic [63:0]        ps_s1;
	logic [32:0]        tc_s1, tc_s2;
	logic [31:0]        s_s2;
	logic [F:0]         su_s3, cu_s3;
	logic signed [F+1:0] sn_s4, cs_s4;
	logic signed [31:0] ua_s4, ub_s4;
	logic signed [PW-1:0] pca_s5, psb_s5, psa_s5, pcb_s5;
	logic signed [SW-1:0] sa_s6, sb_s6;
	res_t               res_s7;

	logic [32:0]        s_rnd, c_rnd;
	logic signed [F+1:0] sp, cp, sn, cs;
	logic signed [31:0] ua, ub, ra, rb;
	res_t               res;

	function automatic logic signed [31:0] sat(input logic signed [SW-1:0] s);
		logic signed [RW-1:0] r;
		r = RW'(s >>> F);
		if (r > SAT_HI) begin
			sat = 32'sh7fffffff;
		end else if (r < SAT_LO) begin
			sat = 32'sh80000000;
		end else begin
			sat = r[31:0];
		end
	endfunction

	// Round Q0.32 to F fraction bits, half up.
	assign s_rnd = 33'(s_s2) + TRIG_RND;
	assign c_rnd = tc_s2 + TRIG_RND;

	// Quadrant signs and the pair of coordinates that turn.
	always_comb begin
		sp = (F+2)'({1'b0, su_s3});
		cp = (F+2)'({1'b0, cu_s3});
		case (ctx_s3.quad)
			QUAD_I: begin
				sn = sp;
				cs = cp;
			end
			QUAD_II: begin
				sn = cp;
				cs = -sp;
			end
			QUAD_III: begin
				sn = -sp;
				cs = -cp;
			end
			default: begin
				sn = -cp;
				cs = sp;
			end
		endcase
		case (ctx_s3.axis)
			AXIS_X: begin
				ua = ctx_s3.vy;
				ub = ctx_s3.vz;
			end
			AXIS_Y: begin
				ua = ctx_s3.vz;
				ub = ctx_s3.vx;
			end
			default: begin
				ua = ctx_s3.vx;
				ub = ctx_s3.vy;
			end
		endcase
	end

	// Place the turned pair back; the axis coordinate passes through.
	always_comb begin
		ra    = sat(sa_s6);
		rb    = sat(sb_s6);
		res.x = ctx_s6.vx;
		res.y = ctx_s6.vy;
		res.z = ctx_s6.vz;
		case (ctx_s6.axis)
			AXIS_X: begin
				res.y = ra;
				res.z = rb;
			end
			AXIS_Y: begin
				res.z = ra;
				res.x = rb;
			end
			AXIS_Z: begin
				res.x = ra;
				res.y = rb;
			end
			default: begin
				res.x = ctx_s6.vx;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= term_i.ctx;
			ps_s1  <= 64'(term_i.x) * 64'(term_i.ts);
			tc_s1  <= term_i.tc;

			ctx_s2 <= ctx_s1;
			s_s2   <= ps_s1[63:32] + 32'(ps_s1[31]);
			tc_s2  <= tc_s1;

			ctx_s3 <= ctx_s2;
			su_s3  <= ctx_s2.swap ? c_rnd[32:32-F] : s_rnd[32:32-F];
			cu_s3  <= ctx_s2.swap ? s_rnd[32:32-F] : c_rnd[32:32-F];

			ctx_s4 <= ctx_s3;
			sn_s4  <= sn;
			cs_s4  <= cs;
			ua_s4  <= ua;
			ub_s4  <= ub;

			ctx_s5 <= ctx_s4;
			pca_s5 <= PW'(cs_s4) * PW'(ua_s4);
			psb_s5 <= PW'(sn_s4) * PW'(ub_s4);
			psa_s5 <= PW'(sn_s4) * PW'(ua_s4);
			pcb_s5 <= PW'(cs_s4) * PW'(ub_s4);

			ctx_s6 <= ctx_s5;
			sa_s6  <= SW'(pca_s5) - SW'(psb_s5) + SUM_RND;
			sb_s6  <= SW'(psa_s5) + SW'(pcb_s5) + SUM_RND;

			res_s7 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
		end else if (en) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <=
				{vld_i, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6};
		end
	end

	assign vld_o = vld_s7;
	assign res_o = res_s7;

endmodule
